>>> hdl/otrg_pkg.sv
// Shared types, constants and arithmetic helpers for the overlap tile region generator.
package otrg_pkg;

	localparam int DIM_W    = 14;
	localparam int OUT_W    = 17;
	localparam int TMAX_W   = 13;
	localparam int PAD_W    = 10;
	localparam int SCL_SH   = 3;
	localparam int DIV_BITS = 4;
	localparam int DVD_W    = 16;
	localparam int PROD_W   = 2 * DIM_W;
	localparam int AX_STG   = 15;
	localparam int NSTG     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 14;
	localparam int IN_TD_W  = 32;
	localparam int OUT_TD_W = 160;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TMAX   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADCFG = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;
	localparam logic [1:0] ST_REJECT = 2'd3;

	typedef struct packed {
		logic [DVD_W-1:0] q;
		logic [DVD_W-1:0] dvd;
		logic [DIM_W-1:0] rem;
	} div_t;

	typedef struct packed {
		logic [DIM_W-1:0] idx;
		logic             whole;
		logic [DIM_W-1:0] inner;
		logic [DIM_W-1:0] cnt;
	} ctx_t;

	typedef struct packed {
		logic [DIM_W-1:0] cnt;
		logic [DIM_W-1:0] is;
		logic [DIM_W-1:0] ie;
		logic [DIM_W-1:0] vs;
		logic [DIM_W-1:0] ve;
		logic             rej;
	} axis_res_t;

	// restoring division, DIV_BITS quotient bits per call
	function automatic div_t div_step(input div_t d, input logic [DIM_W-1:0] dvs);
		div_t o;
		logic [DIM_W:0] rw;
		logic qb;
		o = d;
		for (int j = 0; j < DIV_BITS; j++) begin
			rw = {o.rem, o.dvd[DVD_W-1]};
			o.dvd = {o.dvd[DVD_W-2:0], 1'b0};
			if (rw >= {1'b0, dvs}) begin
				rw = rw - {1'b0, dvs};
				qb = 1'b1;
			end else begin
				qb = 1'b0;
			end
			o.rem = rw[DIM_W-1:0];
			o.q = {o.q[DVD_W-2:0], qb};
		end
		return o;
	endfunction

	// round up to the first multiple of 32, 16, 8, 4 or 2 that stays within hi
	function automatic logic [DIM_W-1:0] round_tile(input logic [DIM_W-1:0] lo,
			input logic [TMAX_W-1:0] hi);
		logic [DIM_W:0] dd;
		logic [DIM_W:0] r;
		logic [DIM_W:0] cand;
		logic [DIM_W-1:0] res;
		logic done;
		res = lo;
		done = 1'b0;
		for (int k = 5; k >= 1; k--) begin
			dd = (DIM_W+1)'(1) << k;
			r = {1'b0, lo} & (dd - (DIM_W+1)'(1));
			cand = {1'b0, lo} - r + dd;
			if (!done) begin
				if (r == '0) begin
					done = 1'b1;
				end else if (cand <= {2'b0, hi}) begin
					res = cand[DIM_W-1:0];
					done = 1'b1;
				end
			end
		end
		return res;
	endfunction

endpackage

>>> hdl/overlap_tile_region_generator_unit.sv
// Throughput: one word per cycle while m_axis_tready keeps the output moving;
// each axis runs two 4-stage dividers (4 quotient bits per stage), rounding,
// a multiply and the edge stages.
// Stages advance independently, so bubbles close up under output stalls.
// Reset (arst_n low) clears all configuration registers and valid bits.
module overlap_tile_region_generator_unit
	import otrg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// column_index[13:0], row_index[27:14], zero fill
	input  logic [IN_TD_W-1:0]   s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// in_left, in_top, in_cols, in_rows (14 each), out_left, out_top, out_cols,
	// out_rows (17 each), tiles_across, tiles_down (14 each), status (2), zero fill
	output logic [OUT_TD_W-1:0]  m_axis_tdata
);

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [TMAX_W-1:0] tmax_q;
	logic [PAD_W-1:0]  pad_q;
	logic              mode_q;

	logic [NSTG:1] v_q;
	logic [NSTG:1] en;
	axis_res_t     rx, ry;

	logic [DIM_W-1:0] in_left_s16, in_top_s16, in_cols_s16, in_rows_s16;
	logic [OUT_W-1:0] out_left_s16, out_top_s16, out_cols_s16, out_rows_s16;
	logic [DIM_W-1:0] tx_s16, ty_s16;
	logic [1:0]       status_s16;

	logic             bad_c;
	logic [OUT_W-1:0] ox1, ox2, oy1, oy2;
	logic [1:0]       status_c;

	// tile indexes delayed alongside the axis pipelines
	logic [2*DIM_W-1:0] idx_s [1:AX_STG];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			tmax_q   <= '0;
			pad_q    <= '0;
			mode_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_TMAX:   tmax_q   <= cfg_data[TMAX_W-1:0];
				REG_PAD:    pad_q    <= cfg_data[PAD_W-1:0];
				REG_MODE:   mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// per-stage advance: a stage moves when empty or when the next one moves
	always_comb begin
		en[NSTG] = !v_q[NSTG] || m_axis_tready;
		for (int k = NSTG - 1; k >= 1; k--) en[k] = !v_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) v_q[1] <= s_axis_tvalid;
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = v_q[NSTG];

	otrg_axis u_ax_x (
		.clk  (clk),
		.en   (en[AX_STG:1]),
		.len  (width_q),
		.pad  (pad_q),
		.tmax (tmax_q),
		.idx  (s_axis_tdata[DIM_W-1:0]),
		.res  (rx)
	);

	otrg_axis u_ax_y (
		.clk  (clk),
		.en   (en[AX_STG:1]),
		.len  (height_q),
		.pad  (pad_q),
		.tmax (tmax_q),
		.idx  (s_axis_tdata[2*DIM_W-1:DIM_W]),
		.res  (ry)
	);

	// configuration check, scaling and status
	assign bad_c = (width_q == '0) || (height_q == '0) || (tmax_q == '0) ||
		(!mode_q && ((width_q[SCL_SH-1:0] != '0) || (height_q[SCL_SH-1:0] != '0)));

	assign ox1 = mode_q ? {rx.vs, SCL_SH'(0)} : OUT_W'(rx.vs >> SCL_SH);
	assign ox2 = mode_q ? {rx.ve, SCL_SH'(0)} : OUT_W'(rx.ve >> SCL_SH);
	assign oy1 = mode_q ? {ry.vs, SCL_SH'(0)} : OUT_W'(ry.vs >> SCL_SH);
	assign oy2 = mode_q ? {ry.ve, SCL_SH'(0)} : OUT_W'(ry.ve >> SCL_SH);

	always_comb begin
		priority if (bad_c) status_c = ST_BADCFG;
		else if (idx_s[AX_STG][DIM_W-1:0] >= rx.cnt ||
			idx_s[AX_STG][2*DIM_W-1:DIM_W] >= ry.cnt) status_c = ST_RANGE;
		else if (rx.rej || ry.rej || ox2 <= ox1 || oy2 <= oy1) status_c = ST_REJECT;
		else status_c = ST_OK;
	end

	// output register
	always_ff @(posedge clk) begin
		if (en[NSTG]) begin
			status_s16   <= status_c;
			tx_s16       <= bad_c ? '0 : rx.cnt;
			ty_s16       <= bad_c ? '0 : ry.cnt;
			if (status_c == ST_OK) begin
				in_left_s16  <= rx.is;
				in_top_s16   <= ry.is;
				in_cols_s16  <= rx.ie - rx.is;
				in_rows_s16  <= ry.ie - ry.is;
				out_left_s16 <= ox1;
				out_top_s16  <= oy1;
				out_cols_s16 <= ox2 - ox1;
				out_rows_s16 <= oy2 - oy1;
			end else begin
				in_left_s16  <= '0;
				in_top_s16   <= '0;
				in_cols_s16  <= '0;
				in_rows_s16  <= '0;
				out_left_s16 <= '0;
				out_top_s16  <= '0;
				out_cols_s16 <= '0;
				out_rows_s16 <= '0;
			end
		end
	end

	// index delay line
	always_ff @(posedge clk) begin
		if (en[1]) idx_s[1] <= s_axis_tdata[2*DIM_W-1:0];
		for (int k = 2; k <= AX_STG; k++) begin
			if (en[k]) idx_s[k] <= idx_s[k-1];
		end
	end

	assign m_axis_tdata = {6'b0, status_s16, ty_s16, tx_s16,
		out_rows_s16, out_cols_s16, out_top_s16, out_left_s16,
		in_rows_s16, in_cols_s16, in_top_s16, in_left_s16};

	// a full stall backs up only when every stage holds a word
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> &v_q)
		else $error("input blocked while a stage is empty");

	// a good tile never has an empty region
	a_ok_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status_s16 == ST_OK |->
			in_cols_s16 != '0 && in_rows_s16 != '0 &&
			out_cols_s16 != '0 && out_rows_s16 != '0)
		else $error("empty region reported as ok");

	// bad configuration reports no tile counts
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status_s16 == ST_BADCFG |-> tx_s16 == '0 && ty_s16 == '0)
		else $error("tile counts reported with bad configuration");

	// a good tile always reports nonzero tile counts
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status_s16 == ST_OK |-> tx_s16 != '0 && ty_s16 != '0)
		else $error("ok result with zero tile count");

endmodule

>>> hdl/otrg_axis.sv
// One axis of the tile plan: two pipelined dividers, rounding, multiply and region edges.
module otrg_axis
	import otrg_pkg::*;
(
	input  logic              clk,
	input  logic [AX_STG:1]   en,
	input  logic [DIM_W-1:0]  len,
	input  logic [PAD_W-1:0]  pad,
	input  logic [TMAX_W-1:0] tmax,
	input  logic [DIM_W-1:0]  idx,
	output axis_res_t         res
);

	ctx_t             ctx_s [1:AX_STG-1];
	div_t             dv1_s [1:5];
	div_t             dv2_s [6:10];
	logic [DIM_W-1:0] core_s11;
	logic [DIM_W-1:0] core_s12;
	logic [PROD_W-1:0] prod_s12;
	logic [PROD_W:0]  cs_s13;
	logic [PROD_W:0]  ce_s13;
	logic [DIM_W-1:0] cs_s14;
	logic [DIM_W-1:0] ce_s14;
	logic             rej_s14;
	axis_res_t        res_s15;

	logic [DIM_W-1:0] inner_c;
	logic             whole_c;
	logic [DIM_W-1:0] cnt_c;
	logic [DIM_W-1:0] core0_c;
	axis_res_t        res_c;
	logic [DIM_W:0]   ie_sum;
	logic [DIM_W-1:0] len_less_pad;

	// inner length and whole-axis test at entry
	assign whole_c = {1'b0, len} <= {4'b0, pad, 1'b0};
	assign inner_c = len - {3'b0, pad, 1'b0};

	// ceiling corrections after each division
	assign cnt_c   = dv1_s[5].q[DIM_W-1:0] + DIM_W'(dv1_s[5].rem != '0);
	assign core0_c = dv2_s[10].q[DIM_W-1:0] + DIM_W'(dv2_s[10].rem != '0);

	always_ff @(posedge clk) begin
		// context travels with the item
		if (en[1]) begin
			ctx_s[1] <= '{idx: idx, whole: whole_c, inner: inner_c, cnt: '0};
			dv1_s[1] <= '{q: '0, dvd: {2'b0, inner_c}, rem: '0};
		end
		for (int k = 2; k <= AX_STG - 1; k++) begin
			if (en[k] && k != 6) ctx_s[k] <= ctx_s[k-1];
		end
		// tile count: ceil(inner / tmax)
		for (int k = 2; k <= 5; k++) begin
			if (en[k]) dv1_s[k] <= div_step(dv1_s[k-1], {1'b0, tmax});
		end
		if (en[6]) begin
			ctx_s[6] <= '{idx: ctx_s[5].idx, whole: ctx_s[5].whole, inner: ctx_s[5].inner,
				cnt: ctx_s[5].whole ? DIM_W'(1) : cnt_c};
			dv2_s[6] <= '{q: '0, dvd: {2'b0, ctx_s[5].inner}, rem: '0};
		end
		// core size: ceil(inner / count)
		for (int k = 7; k <= 10; k++) begin
			if (en[k]) dv2_s[k] <= div_step(dv2_s[k-1], ctx_s[k-1].cnt);
		end
		if (en[11]) core_s11 <= ctx_s[10].whole ? '0 : round_tile(core0_c, tmax);
		if (en[12]) begin
			prod_s12 <= ctx_s[11].idx * core_s11;
			core_s12 <= core_s11;
		end
		// core start and raw end
		if (en[13]) begin
			cs_s13 <= {1'b0, prod_s12} + (PROD_W+1)'(pad);
			ce_s13 <= {1'b0, prod_s12} + (PROD_W+1)'(pad) + (PROD_W+1)'(core_s12);
		end
		// start test and end clip
		if (en[14]) begin
			rej_s14 <= cs_s13 >= (PROD_W+1)'(len);
			ce_s14  <= (ce_s13 > (PROD_W+1)'(len)) ? len : ce_s13[DIM_W-1:0];
			cs_s14  <= cs_s13[DIM_W-1:0];
		end
		if (en[15]) res_s15 <= res_c;
	end

	// region edges and the tile's own checks
	assign len_less_pad = len - DIM_W'(pad);
	assign ie_sum = {1'b0, ce_s14} + (DIM_W+1)'(pad);

	always_comb begin
		res_c.cnt = ctx_s[14].cnt;
		if (ctx_s[14].whole) begin
			res_c.is  = '0;
			res_c.ie  = len;
			res_c.vs  = '0;
			res_c.ve  = len;
			res_c.rej = (len == '0);
		end else begin
			res_c.vs  = (cs_s14 > DIM_W'(pad)) ? cs_s14 : '0;
			res_c.ve  = (ce_s14 < len_less_pad) ? ce_s14 : len;
			res_c.is  = cs_s14 - DIM_W'(pad);
			res_c.ie  = (ie_sum < {1'b0, len}) ? ie_sum[DIM_W-1:0] : len;
			res_c.rej = rej_s14 || !(res_c.ie > res_c.is && res_c.ve > res_c.vs &&
				res_c.ve <= len);
		end
	end

	assign res = res_s15;

endmodule
